// ===== design/pjw_string_hash_bucket_defines.svh =====
// assertion macros of the pjw hash bucket block, used by pjw_mod_serial
// no dependencies; expects clk and arst_n in the including scope
`ifndef PJW_STRING_HASH_BUCKET_DEFINES_SVH
`define PJW_STRING_HASH_BUCKET_DEFINES_SVH

// checked only outside reset
`define PJW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PJW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pjw_pkg.sv =====
// shared widths, register indexes and transaction types of the pjw hash bucket block
// no dependencies
package pjw_pkg;

	localparam int HASH_W     = 28;
	localparam int BUCKET_W   = 31;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_SIGNED  = 1'd1;

	localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RST = 31'd256;
	localparam logic                CHAR_SIGNED_RST  = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] key_byte;
		logic              has_byte;
		logic              last;
	} key_item_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket_index;
		logic [HASH_W-1:0]   raw_hash;
	} bucket_item_t;

	typedef struct packed {
		logic [HASH_W-1:0] raw_hash;
	} hash_job_t;

endpackage

// ===== design/pjw_stream_if.sv =====
// valid/ready stream channel carrying one payload per transaction
// payload type is a parameter, normally a struct from pjw_pkg
interface pjw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/pjw_mixer.sv =====
// byte-wise pjw hash update, hands the final hash of each key to the reducer
// depends on pjw_pkg and pjw_stream_if
module pjw_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_signed,
	pjw_stream_if.sink          keys,
	output pjw_pkg::hash_job_t  job,
	output logic                job_valid,
	input  logic                job_ready
);

	function automatic logic [pjw_pkg::HASH_W-1:0] mix_byte(
		input logic [pjw_pkg::HASH_W-1:0] acc,
		input logic [pjw_pkg::BYTE_W-1:0] b,
		input logic                       sext
	);
		logic [31:0] addend;
		logic [31:0] sum;
		logic [3:0]  top;
		addend = {{24{sext & b[7]}}, b};
		sum    = {acc, 4'b0} + addend;
		top    = sum[31:28];
		// fold the top nibble into bits 7..4; xor with zero leaves them alone
		return {sum[27:8], sum[7:4] ^ top, sum[3:0]};
	endfunction

	logic [pjw_pkg::HASH_W-1:0] hash_q;
	logic [pjw_pkg::HASH_W-1:0] hash_nx;
	pjw_pkg::hash_job_t         job_q;
	logic                       job_valid_q;
	logic                       accept;

	assign keys.ready = !job_valid_q || job_ready;
	assign accept     = keys.valid && keys.ready;
	assign hash_nx    = keys.data.has_byte ? mix_byte(hash_q, keys.data.key_byte, char_signed)
	                                       : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= '0;
			job_valid_q <= 1'b0;
		end else begin
			if (accept && keys.data.last) begin
				job_valid_q <= 1'b1;
			end else if (job_valid_q && job_ready) begin
				job_valid_q <= 1'b0;
			end
			if (accept) begin
				if (keys.data.last) begin
					hash_q <= '0;
				end else begin
					hash_q <= hash_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keys.data.last) begin
			job_q.raw_hash <= hash_nx;
		end
	end

	assign job       = job_q;
	assign job_valid = job_valid_q;

endmodule

// ===== design/pjw_mod_serial.sv =====
// bit-serial restoring modulo of the final hash by bucket_count, plus output register
// depends on pjw_pkg, pjw_stream_if and pjw_string_hash_bucket_defines.svh
`include "pjw_string_hash_bucket_defines.svh"

module pjw_mod_serial (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pjw_pkg::BUCKET_W-1:0]  bucket_count,
	input  pjw_pkg::hash_job_t            job,
	input  logic                          job_valid,
	output logic                          job_ready,
	pjw_stream_if.source                  buckets
);

	localparam int CNT_W = $clog2(pjw_pkg::HASH_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pjw_pkg::HASH_W - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [pjw_pkg::HASH_W-1:0]   dividend_q;
	logic [pjw_pkg::HASH_W-1:0]   raw_q;
	logic [pjw_pkg::BUCKET_W-1:0] div_q;
	logic [pjw_pkg::BUCKET_W-1:0] rem_q;
	logic [pjw_pkg::BUCKET_W:0]   trial;
	logic [pjw_pkg::BUCKET_W:0]   divisor_ext;
	logic                         ge;
	logic [pjw_pkg::BUCKET_W-1:0] rem_nx;
	pjw_pkg::bucket_item_t        out_q;
	logic                         out_valid_q;
	logic                         out_load;

	assign job_ready   = (state_q == S_IDLE);
	assign divisor_ext = {1'b0, div_q};
	assign trial       = {rem_q, dividend_q[pjw_pkg::HASH_W-1]};
	assign ge          = (trial >= divisor_ext);
	// below the divisor the trial value fits in the remainder width
	assign rem_nx      = ge ? pjw_pkg::BUCKET_W'(trial - divisor_ext)
	                        : trial[pjw_pkg::BUCKET_W-1:0];
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || buckets.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (buckets.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_RUN;
						cnt_q   <= '0;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && job_valid) begin
			dividend_q <= job.raw_hash;
			raw_q      <= job.raw_hash;
			div_q      <= bucket_count;
			rem_q      <= '0;
		end else if (state_q == S_RUN) begin
			dividend_q <= {dividend_q[pjw_pkg::HASH_W-2:0], 1'b0};
			rem_q      <= rem_nx;
		end
		if (out_load) begin
			// zero bucket count reports bucket zero
			out_q.bucket_index <= (div_q == '0) ? '0 : rem_q;
			out_q.raw_hash     <= raw_q;
		end
	end

	assign buckets.valid = out_valid_q;
	assign buckets.data  = out_q;

	`PJW_ASSERT(a_rem_below_div,
		(state_q == S_RUN && div_q != '0) |-> (rem_q < div_q),
		"remainder not below divisor")
	`PJW_ASSERT(a_out_from_done,
		$rose(out_valid_q) |-> $past(state_q == S_DONE),
		"result without finished division")
	`PJW_ASSERT(a_cnt_bound,
		(state_q != S_RUN) || (cnt_q <= CNT_LAST),
		"bit counter overran")

endmodule

// ===== design/pjw_string_hash_bucket.sv =====
// pjw string hash with bucket reduction: one key byte per cycle, final modulo bit-serial.
// throughput: one byte per cycle unless a finished key still waits for the modulo unit;
// bytes of the next key flow in while a hash is reduced, but its end waits for the
// 28-step serial modulo unit (one hash bit per cycle) to take it.
// reset: async active low; clears running hash, handshakes, bucket_count=256, char_signed=1.
// depends on pjw_pkg, pjw_stream_if, pjw_mixer and pjw_mod_serial
module pjw_string_hash_bucket (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pjw_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pjw_pkg::CFG_DATA_W-1:0]   cfg_data,
	pjw_stream_if.sink                       keys,
	pjw_stream_if.source                     buckets
);

	logic [pjw_pkg::BUCKET_W-1:0] bucket_count_q;
	logic                         char_signed_q;
	pjw_pkg::hash_job_t           job;
	logic                         job_valid;
	logic                         job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= pjw_pkg::BUCKET_COUNT_RST;
			char_signed_q  <= pjw_pkg::CHAR_SIGNED_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pjw_pkg::REG_BUCKET_COUNT: bucket_count_q <= cfg_data[pjw_pkg::BUCKET_W-1:0];
				pjw_pkg::REG_CHAR_SIGNED:  char_signed_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pjw_mixer u_mixer (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_signed (char_signed_q),
		.keys        (keys),
		.job         (job),
		.job_valid   (job_valid),
		.job_ready   (job_ready)
	);

	pjw_mod_serial u_mod (
		.clk          (clk),
		.arst_n       (arst_n),
		.bucket_count (bucket_count_q),
		.job          (job),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.buckets      (buckets)
	);

endmodule
